// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  // Header field codes
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_BINARY   = 4'h2;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] MASK_BYTES  = 3'd4;

  // frame_kind codes
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_BINARY = 2'd2;

  // Queue between parser and unmasking stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic [1:0] frame_kind;
    logic       is_close;
    logic       frame_end;
  } out_item_t;

  // Classified byte handed from parser to unmasking stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       has_data;
    logic [1:0] frame_kind;
    logic       is_close;
    logic       frame_end;
  } job_t;

endpackage

// ===== rtl/wsd_front.sv =====
module wsd_front
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t din,
  output logic     emit,
  output job_t     job
);

  phase_t          phase, phase_next;
  logic [3:0]      ext_remaining, ext_remaining_next;
  logic [3:0][7:0] mask_key, mask_key_next;
  logic [2:0]      mask_count, mask_count_next;
  logic [1:0]      payload_lane, payload_lane_next;
  logic [1:0]      kind_held, kind_held_next;
  logic            close_held, close_held_next;
  logic            has;
  logic [6:0]      len_code;
  logic [3:0]      opcode;

  always_comb begin
    phase_next         = phase;
    ext_remaining_next = ext_remaining;
    mask_key_next      = mask_key;
    mask_count_next    = mask_count;
    payload_lane_next  = payload_lane;
    kind_held_next     = kind_held;
    close_held_next    = close_held;
    has                = 1'b0;
    len_code           = din.rx_byte[6:0];
    opcode             = din.rx_byte[3:0];
    case (phase)
      PH_HDR1: begin
        if (len_code == LEN_CODE_16) begin
          ext_remaining_next = EXT_BYTES_16;
        end else if (len_code == LEN_CODE_64) begin
          ext_remaining_next = EXT_BYTES_64;
        end else begin
          ext_remaining_next = '0;
        end
        mask_key_next   = '0;
        mask_count_next = '0;
        phase_next      = (ext_remaining_next != '0) ? PH_EXT : PH_MASK;
      end
      PH_EXT: begin
        ext_remaining_next = ext_remaining - 4'd1;
        if (ext_remaining_next == '0) begin
          phase_next = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key_next[mask_count[1:0]] = mask_key[mask_count[1:0]] | din.rx_byte;
        mask_count_next = mask_count + 3'd1;
        if (mask_count_next >= MASK_BYTES) begin
          phase_next        = PH_DATA;
          payload_lane_next = '0;
        end
      end
      PH_DATA: begin
        if (!close_held) begin
          has               = 1'b1;
          payload_lane_next = payload_lane + 2'd1;
        end
      end
      default: begin
        close_held_next = (opcode == OP_CLOSE);
        if (opcode == OP_TEXT) begin
          kind_held_next = KIND_TEXT;
        end else if (opcode == OP_BINARY) begin
          kind_held_next = KIND_BINARY;
        end else begin
          kind_held_next = KIND_OTHER;
        end
        phase_next = PH_HDR1;
      end
    endcase
  end

  assign emit           = has | din.frame_last;
  assign job.data       = din.rx_byte;
  assign job.mask       = mask_key[payload_lane];
  assign job.has_data   = has;
  assign job.frame_kind = kind_held_next;
  assign job.is_close   = close_held_next;
  assign job.frame_end  = din.frame_last;

  always_ff @(posedge clk) begin
    if (rst || (accept && din.frame_last)) begin
      phase         <= PH_HDR0;
      ext_remaining <= '0;
      mask_key      <= '0;
      mask_count    <= '0;
      payload_lane  <= '0;
      kind_held     <= KIND_OTHER;
      close_held    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      ext_remaining <= ext_remaining_next;
      mask_key      <= mask_key_next;
      mask_count    <= mask_count_next;
      payload_lane  <= payload_lane_next;
      kind_held     <= kind_held_next;
      close_held    <= close_held_next;
    end
  end

endmodule

// ===== rtl/wsd_queue.sv =====
module wsd_queue
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  input  logic rd,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full   = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/wsd_back.sv =====
module wsd_back
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_avail,
  input  job_t      job,
  output logic      job_take,
  input  logic      pop,
  output logic      empty,
  output out_item_t dout
);

  logic      out_valid;
  out_item_t out_reg;

  // Refill the output register when it is free or being drained this cycle
  assign job_take = job_avail && (!out_valid || pop);
  assign empty    = !out_valid;
  assign dout     = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      out_reg.payload_byte <= job.has_data ? (job.data ^ job.mask) : 8'h00;
      out_reg.has_data     <= job.has_data;
      out_reg.frame_kind   <= job.frame_kind;
      out_reg.is_close     <= job.is_close;
      out_reg.frame_end    <= job.frame_end;
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Receive-side WebSocket deframer: one frame byte in, at most one unmasked
// payload byte out.
// Input queue side: present din (rx_byte, frame_last) and raise push; the
// transfer happens on a rising edge with push high and full low. frame_last
// marks the final byte of a frame; the next byte starts a new frame.
// Result queue side: while empty is low the oldest result sits on dout; it
// is removed on a rising edge with pop high. Header, extended length and
// mask bytes give no result unless they close the frame; close frames give
// only the final end-of-frame result.
// Throughput: one byte per cycle while full is low. A result reaches dout
// through the queue (written on the edge that takes its byte) and then the
// output register, provided no older result is waiting.
// When the receiver stalls, results collect in the four-entry queue and the
// output register; full rises once both are occupied, and nothing is lost.
// Reset (rst, synchronous, active high) empties the queue and output stage
// and returns the parser to the first header byte.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  din,
  input  logic      pop,
  output logic      empty,
  output out_item_t dout
);

  logic accept;
  logic emit;
  job_t front_job;
  job_t queue_job;
  logic queue_empty;
  logic job_take;

  // Every accepted byte may need a queue slot, so back-pressure follows the
  // queue's fill level directly.
  assign accept = push && !full;

  // Parser: tracks header phase, mask key and payload lane
  wsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .din    (din),
    .emit   (emit),
    .job    (front_job)
  );

  // Decoupling queue: only bytes that yield a result are written
  wsd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept && emit),
    .wr_job (front_job),
    .rd     (job_take),
    .rd_job (queue_job),
    .full   (full),
    .empty  (queue_empty)
  );

  // Unmasking and output register
  wsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (!queue_empty),
    .job       (queue_job),
    .job_take  (job_take),
    .pop       (pop),
    .empty     (empty),
    .dout      (dout)
  );

endmodule

// ===== sim/wsd_checker.sv =====
`timescale 1ns / 100ps

// Watches both queue ports of the deframer, keeps its own copy of the
// frame parser and compares every popped result with the oldest one due.
module wsd_checker
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  din,
  input  logic      pop,
  input  logic      empty,
  input  out_item_t dout,
  output int        fails,
  output int        pending
);

  phase_t      ph;
  logic [3:0]  ext_left;
  logic [31:0] key;
  logic [2:0]  key_cnt;
  logic [1:0]  lane;
  logic [1:0]  kind;
  logic        close_f;

  out_item_t   deframed_q[$];
  int          fail_cnt = 0;
  int          due_cnt = 0;

  assign fails   = fail_cnt;
  assign pending = due_cnt;

  task automatic clear_parse();
    ph       = PH_HDR0;
    ext_left = '0;
    key      = '0;
    key_cnt  = '0;
    lane     = '0;
    kind     = KIND_OTHER;
    close_f  = 1'b0;
  endtask

  // One received byte through the parser; emits is set when a result is due.
  task automatic deframe(input in_item_t it, output bit emits, output out_item_t res);
    logic [6:0] code;
    logic [3:0] op;
    res = '0;
    case (ph)
      PH_HDR1: begin
        code     = it.rx_byte[6:0];
        ext_left = (code == LEN_CODE_16) ? EXT_BYTES_16 :
                   (code == LEN_CODE_64) ? EXT_BYTES_64 : 4'd0;
        key      = '0;
        key_cnt  = '0;
        ph       = (ext_left != 4'd0) ? PH_EXT : PH_MASK;
      end
      PH_EXT: begin
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) ph = PH_MASK;
      end
      PH_MASK: begin
        key     = key | ({24'd0, it.rx_byte} << (8 * key_cnt[1:0]));
        key_cnt = key_cnt + 3'd1;
        if (key_cnt >= MASK_BYTES) begin
          ph   = PH_DATA;
          lane = '0;
        end
      end
      PH_DATA: begin
        if (!close_f) begin
          res.payload_byte = it.rx_byte ^ key[8 * lane +: 8];
          res.has_data     = 1'b1;
          lane             = lane + 2'd1;
        end
      end
      default: begin
        op      = it.rx_byte[3:0];
        close_f = (op == OP_CLOSE);
        kind    = (op == OP_TEXT) ? KIND_TEXT : (op == OP_BINARY) ? KIND_BINARY : KIND_OTHER;
        ph      = PH_HDR1;
      end
    endcase
    emits          = res.has_data || it.frame_last;
    res.frame_kind = kind;
    res.is_close   = close_f;
    res.frame_end  = it.frame_last;
    if (it.frame_last) clear_parse();
  endtask

  task automatic note_field(input string field, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    bit        emits;
    out_item_t res;
    out_item_t due;
    if (rst) begin
      clear_parse();
      deframed_q.delete();
    end else begin
      if (pop && !empty) begin
        if (deframed_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, actual %h", $time, dout);
        end else begin
          due = deframed_q.pop_front();
          note_field("payload_byte", due.payload_byte, dout.payload_byte);
          note_field("has_data", {7'd0, due.has_data}, {7'd0, dout.has_data});
          note_field("frame_kind", {6'd0, due.frame_kind}, {6'd0, dout.frame_kind});
          note_field("is_close", {7'd0, due.is_close}, {7'd0, dout.is_close});
          note_field("frame_end", {7'd0, due.frame_end}, {7'd0, dout.frame_end});
        end
      end
      if (push && !full) begin
        deframe(din, emits, res);
        if (emits) deframed_q.insert(deframed_q.size(), res);
      end
    end
    due_cnt = deframed_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Top of the deframer bench: builds the byte stream, drives the input queue
// port, pops results with random stalls and gives the verdict. All
// prediction and comparison lives in wsd_checker.
module tb_top;
  import wsd_pkg::*;

  localparam int RANDOM_BYTES = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam logic [3:0] OP_CONT = 4'h0; // continuation opcode

  logic      clk;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  din = '0;
  logic      pop = 1'b0;
  logic      empty;
  out_item_t dout;

  int        fails;
  int        pending;

  in_item_t  wire_bytes[$];   // whole byte stream, in wire order
  int        sent = 0;        // bytes transferred so far
  bit        calm = 1'b0;     // set for the closing stretch: no idling either side
  int        cycle_count = 0;

  websocket_frame_deframer u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (din),
    .pop   (pop),
    .empty (empty),
    .dout  (dout)
  );

  wsd_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .din     (din),
    .pop     (pop),
    .empty   (empty),
    .dout    (dout),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic put(input logic [7:0] b, input logic last);
    in_item_t it;
    it.rx_byte    = b;
    it.frame_last = last;
    wire_bytes.insert(wire_bytes.size(), it);
  endtask

  // Mostly well-formed frames with random content; about one in seven is cut
  // short somewhere in the header, and one in ten is plain noise.
  task automatic add_random_frame();
    logic [7:0] frame[$];
    logic [7:0] b0;
    logic [6:0] code;
    int         pick;
    int         ext_n;
    int         plen;
    int         cut;
    if ($urandom_range(0, 9) == 0) begin
      plen = $urandom_range(1, 6);
      for (int i = 0; i < plen; i++) frame.insert(frame.size(), 8'($urandom));
    end else begin
      b0   = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3)       b0[3:0] = OP_TEXT;
      else if (pick < 6)  b0[3:0] = OP_BINARY;
      else if (pick < 8)  b0[3:0] = OP_CLOSE;
      else if (pick == 8) b0[3:0] = OP_CONT;
      frame.insert(frame.size(), b0);
      pick = $urandom_range(0, 9);
      if (pick < 6)      code = 7'($urandom_range(0, 125));
      else if (pick < 8) code = LEN_CODE_16;
      else               code = LEN_CODE_64;
      frame.insert(frame.size(), {1'($urandom_range(0, 1)), code});
      ext_n = (code == LEN_CODE_16) ? EXT_BYTES_16 : (code == LEN_CODE_64) ? EXT_BYTES_64 : 0;
      for (int i = 0; i < ext_n; i++) frame.insert(frame.size(), 8'($urandom));
      for (int i = 0; i < MASK_BYTES; i++) frame.insert(frame.size(), 8'($urandom));
      plen = $urandom_range(0, 12);
      for (int i = 0; i < plen; i++) frame.insert(frame.size(), 8'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, 2 + ext_n + MASK_BYTES);
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end
    foreach (frame[i]) put(frame[i], i == frame.size() - 1);
  endtask

  // Receiver: random pop stalls, plus one long hold-off a third of the way in
  // so the internal queue fills and full pushes back on the sender.
  initial begin
    int gap;
    bit held;
    gap  = 0;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && sent >= wire_bytes.size() / 3) begin
        held = 1'b1;
        pop <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        if (gap == 0 && !calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
          pop <= 1'b0;
          gap--;
        end else begin
          pop <= 1'b1;
        end
        @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int gap;
    int total;
    gap = 0;

    // Directed frames first.
    put(8'h88, 1'b1);                          // one-byte close frame
    put(8'h81, 1'b0); put(8'h7E, 1'b1);        // ends on the length byte
    put(8'h82, 1'b0); put(8'hFE, 1'b0);        // 16-bit length, ends in extension
    put(8'h00, 1'b1);
    put(8'h8F, 1'b0); put(8'h80, 1'b0);        // other opcode, ends inside mask
    put(8'hAA, 1'b0); put(8'h55, 1'b0); put(8'hFF, 1'b1);
    put(8'h01, 1'b0); put(8'h00, 1'b0);        // text, no FIN, two payload bytes
    put(8'hFF, 1'b0); put(8'h00, 1'b0); put(8'hFF, 1'b0); put(8'h00, 1'b0);
    put(8'h00, 1'b0); put(8'hFF, 1'b1);
    put(8'h88, 1'b0); put(8'h80, 1'b0);        // close frame with payload
    put(8'h12, 1'b0); put(8'h34, 1'b0); put(8'h56, 1'b0); put(8'h78, 1'b0);
    put(8'h5A, 1'b1);

    total = wire_bytes.size() + RANDOM_BYTES;
    while (wire_bytes.size() < total) add_random_frame();

    for (int c = 0; c < 9; c++) @(posedge clk);
    rst <= 1'b0;

    // Sender: offer bytes with random idle bursts; a byte counts as sent
    // once push was high and full low at the edge just taken.
    while (sent < wire_bytes.size()) begin
      if (sent > wire_bytes.size() * 85 / 100) calm = 1'b1;
      if (gap == 0 && !calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 15);
      if (gap > 0) begin
        push <= 1'b0;
        gap--;
      end else begin
        push <= 1'b1;
        din  <= wire_bytes[sent];
      end
      @(posedge clk);
      if (push && !full) sent++;
    end
    push <= 1'b0;

    // Drain, then idle on to catch anything spurious.
    while (pending != 0) @(posedge clk);
    for (int c = 0; c < 20; c++) @(posedge clk);

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
